// ===== rtl/t2fb_pkg.sv =====
package t2fb_pkg;

   localparam int ROW_BYTES_DEF   = 128;
   localparam int FRAME_BYTES_DEF = 1024;
   localparam int FB_ADDR_W       = 10;
   localparam int LINE_MAX        = 15;

   localparam logic [7:0] CODE_BAR     = 8'h7C;  // '|'
   localparam logic [7:0] CODE_SIZE1   = 8'h31;  // '1'
   localparam logic [7:0] CODE_SIZE2   = 8'h32;  // '2'
   localparam logic [7:0] CODE_SIZE4   = 8'h34;  // '4'
   localparam logic [7:0] CODE_FIRST   = 8'h20;
   localparam logic [7:0] CODE_LAST    = 8'h7E;

   localparam logic [1:0] SIZE_ONE  = 2'd0;
   localparam logic [1:0] SIZE_TWO  = 2'd1;
   localparam logic [1:0] SIZE_FOUR = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       new_text;
   } req_type;

   typedef struct packed {
      logic [FB_ADDR_W-1:0] fb_address;
      logic [7:0]           fb_data;
      logic                 last_write;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic emit;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic glyph;
      logic emit_last;
      logic flush_done;
   } sts_type;

   // Each bit k of the nibble lands on bits 2k and 2k+1.
   function automatic logic [7:0] stretch_nibble(input logic [3:0] n);
      return {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
   endfunction

   // Five font columns, first column in the top byte.
   function automatic logic [39:0] glyph_bits(input logic [6:0] idx);
      logic [39:0] g;
      unique case (idx)
         7'd0:  g = 40'h00_00_00_00_00;
         7'd1:  g = 40'h00_00_5F_00_00;
         7'd2:  g = 40'h00_03_00_03_00;
         7'd3:  g = 40'h14_3E_14_3E_14;
         7'd4:  g = 40'h24_2A_7F_2A_12;
         7'd5:  g = 40'h43_33_08_66_61;
         7'd6:  g = 40'h36_49_55_22_50;
         7'd7:  g = 40'h00_05_03_00_00;
         7'd8:  g = 40'h00_1C_22_41_00;
         7'd9:  g = 40'h00_41_22_1C_00;
         7'd10: g = 40'h14_08_3E_08_14;
         7'd11: g = 40'h08_08_3E_08_08;
         7'd12: g = 40'h00_50_30_00_00;
         7'd13: g = 40'h08_08_08_08_08;
         7'd14: g = 40'h00_60_60_00_00;
         7'd15: g = 40'h20_10_08_04_02;
         7'd16: g = 40'h3E_51_49_45_3E;
         7'd17: g = 40'h00_04_02_7F_00;
         7'd18: g = 40'h42_61_51_49_46;
         7'd19: g = 40'h22_41_49_49_36;
         7'd20: g = 40'h18_14_12_7F_10;
         7'd21: g = 40'h27_45_45_45_39;
         7'd22: g = 40'h3E_49_49_49_32;
         7'd23: g = 40'h01_01_71_09_07;
         7'd24: g = 40'h36_49_49_49_36;
         7'd25: g = 40'h26_49_49_49_3E;
         7'd26: g = 40'h00_36_36_00_00;
         7'd27: g = 40'h00_56_36_00_00;
         7'd28: g = 40'h08_14_22_41_00;
         7'd29: g = 40'h14_14_14_14_14;
         7'd30: g = 40'h00_41_22_14_08;
         7'd31: g = 40'h02_01_51_09_06;
         7'd32: g = 40'h3E_41_59_55_5E;
         7'd33: g = 40'h7E_09_09_09_7E;
         7'd34: g = 40'h7F_49_49_49_36;
         7'd35: g = 40'h3E_41_41_41_22;
         7'd36: g = 40'h7F_41_41_41_3E;
         7'd37: g = 40'h7F_49_49_49_41;
         7'd38: g = 40'h7F_09_09_09_01;
         7'd39: g = 40'h3E_41_41_49_3A;
         7'd40: g = 40'h7F_08_08_08_7F;
         7'd41: g = 40'h00_41_7F_41_00;
         7'd42: g = 40'h30_40_40_40_3F;
         7'd43: g = 40'h7F_08_14_22_41;
         7'd44: g = 40'h7F_40_40_40_40;
         7'd45: g = 40'h7F_02_0C_02_7F;
         7'd46: g = 40'h7F_02_04_08_7F;
         7'd47: g = 40'h3E_41_41_41_3E;
         7'd48: g = 40'h7F_09_09_09_06;
         7'd49: g = 40'h1E_21_21_21_5E;
         7'd50: g = 40'h7F_09_09_09_76;
         7'd51: g = 40'h26_49_49_49_32;
         7'd52: g = 40'h01_01_7F_01_01;
         7'd53: g = 40'h3F_40_40_40_3F;
         7'd54: g = 40'h1F_20_40_20_1F;
         7'd55: g = 40'h7F_20_10_20_7F;
         7'd56: g = 40'h41_22_1C_22_41;
         7'd57: g = 40'h07_08_70_08_07;
         7'd58: g = 40'h61_51_49_45_43;
         7'd59: g = 40'h00_7F_41_00_00;
         7'd60: g = 40'h02_04_08_10_20;
         7'd61: g = 40'h00_00_41_7F_00;
         7'd62: g = 40'h04_02_01_02_04;
         7'd63: g = 40'h40_40_40_40_40;
         7'd64: g = 40'h00_01_02_04_00;
         7'd65: g = 40'h20_54_54_54_78;
         7'd66: g = 40'h7F_44_44_44_38;
         7'd67: g = 40'h38_44_44_44_44;
         7'd68: g = 40'h38_44_44_44_7F;
         7'd69: g = 40'h38_54_54_54_18;
         7'd70: g = 40'h04_04_7E_05_05;
         7'd71: g = 40'h08_54_54_54_3C;
         7'd72: g = 40'h7F_08_04_04_78;
         7'd73: g = 40'h00_44_7D_40_00;
         7'd74: g = 40'h20_40_44_3D_00;
         7'd75: g = 40'h7F_10_28_44_00;
         7'd76: g = 40'h00_41_7F_40_00;
         7'd77: g = 40'h7C_04_78_04_78;
         7'd78: g = 40'h7C_08_04_04_78;
         7'd79: g = 40'h38_44_44_44_38;
         7'd80: g = 40'h7C_14_14_14_08;
         7'd81: g = 40'h08_14_14_14_7C;
         7'd82: g = 40'h00_7C_08_04_04;
         7'd83: g = 40'h48_54_54_54_20;
         7'd84: g = 40'h04_04_3F_44_44;
         7'd85: g = 40'h3C_40_40_20_7C;
         7'd86: g = 40'h1C_20_40_20_1C;
         7'd87: g = 40'h3C_40_30_40_3C;
         7'd88: g = 40'h44_28_10_28_44;
         7'd89: g = 40'h0C_50_50_50_3C;
         7'd90: g = 40'h44_64_54_4C_44;
         7'd91: g = 40'h00_08_36_41_41;
         7'd92: g = 40'h00_00_7F_00_00;
         7'd93: g = 40'h41_41_36_08_00;
         7'd94: g = 40'h48_64_54_48_00;
         default: g = 40'h00_00_00_00_00;
      endcase
      return g;
   endfunction

endpackage

// ===== rtl/t2fb_ctrl.sv =====
module t2fb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output t2fb_pkg::cmd_type cmd,
   input  t2fb_pkg::sts_type sts
);
   import t2fb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LOAD  = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.decode = 1'b1;
            state_in   = sts.glyph ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.emit_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (sts.flush_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== rtl/t2fb_dp.sv =====
module t2fb_dp #(
   parameter int ROW_BYTES   = t2fb_pkg::ROW_BYTES_DEF,
   parameter int FRAME_BYTES = t2fb_pkg::FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  t2fb_pkg::cmd_type cmd,
   output t2fb_pkg::sts_type sts,
   input  t2fb_pkg::req_type req_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output t2fb_pkg::rsp_type rsp_data
);
   import t2fb_pkg::*;

   localparam int PTR_W  = $clog2(FRAME_BYTES + 1);
   localparam int COL_W  = $clog2(ROW_BYTES);
   // wide enough for any candidate address and for row * line
   localparam int ADDR_W = $clog2(FRAME_BYTES + ROW_BYTES * 16 + 16);

   localparam logic [ADDR_W-1:0] F_A        = ADDR_W'(FRAME_BYTES);
   localparam logic [ADDR_W-1:0] R_A        = ADDR_W'(ROW_BYTES);
   localparam logic [COL_W-1:0]  COL_AT_END = COL_W'(FRAME_BYTES % ROW_BYTES);

   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [3:0]        line_ff, line_in;
   logic [1:0]        size_ff, size_in;
   logic [7:0]        code_ff, code_in;
   logic [39:0]       glyph_ff, glyph_in;
   logic [ADDR_W-1:0] run_ff, run_in;
   logic [2:0]        cidx_ff, cidx_in;
   logic [1:0]        sub_ff, sub_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]        pend_data_ff, pend_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // decode
   logic              is_bar, is_digit, in_table;
   logic [3:0]        adv;
   logic [ADDR_W-1:0] adv_sum, bar_addr;
   logic              adv_over, bar_over;
   logic [COL_W:0]    col_sum;
   logic [3:0]        line_inc;
   logic [6:0]        rom_idx;

   // emit
   logic [7:0]        col_byte, cand_data;
   logic [ADDR_W-1:0] cand_off, cand_addr;
   logic [1:0]        last_sub;
   logic              cand_ok, out_free, stall, step_end, push, push_last;

   always_comb begin
      is_bar   = code_ff == CODE_BAR;
      is_digit = (col_ff == '0) &&
                 (code_ff == CODE_SIZE1 || code_ff == CODE_SIZE2 || code_ff == CODE_SIZE4);
      in_table = code_ff >= CODE_FIRST && code_ff <= CODE_LAST;
      rom_idx  = 7'(code_ff - CODE_FIRST);

      if (is_digit)                adv = 4'd1;
      else if (size_ff == SIZE_ONE) adv = 4'd6;
      else                          adv = 4'd11;
      adv_sum  = ADDR_W'(ptr_ff) + ADDR_W'(adv);
      adv_over = adv_sum > F_A;
      col_sum  = {1'b0, col_ff} + (COL_W + 1)'(adv);
      if (col_sum >= (COL_W + 1)'(ROW_BYTES)) col_sum = col_sum - (COL_W + 1)'(ROW_BYTES);

      line_inc = (line_ff < 4'(LINE_MAX)) ? line_ff + 4'd1 : line_ff;
      bar_addr = ADDR_W'(line_inc) * R_A;
      bar_over = bar_addr > F_A;
   end

   always_comb begin
      unique case (cidx_ff)
         3'd0:    col_byte = glyph_ff[39:32];
         3'd1:    col_byte = glyph_ff[31:24];
         3'd2:    col_byte = glyph_ff[23:16];
         3'd3:    col_byte = glyph_ff[15:8];
         3'd4:    col_byte = glyph_ff[7:0];
         default: col_byte = 8'h00;
      endcase

      unique case (size_ff)
         SIZE_ONE: begin
            cand_data = col_byte;
            cand_off  = '0;
            last_sub  = 2'd0;
         end
         SIZE_TWO: begin
            cand_data = col_byte;
            cand_off  = ADDR_W'(sub_ff[0]);
            last_sub  = 2'd1;
         end
         default: begin
            // upper row gets the low nibble, stretched
            cand_data = sub_ff[1] ? stretch_nibble(col_byte[7:4])
                                  : stretch_nibble(col_byte[3:0]);
            cand_off  = (sub_ff[1] ? R_A : '0) + ADDR_W'(sub_ff[0]);
            last_sub  = 2'd3;
         end
      endcase

      cand_addr = run_ff + cand_off;
      cand_ok   = cand_addr < F_A;
      out_free  = !rsp_valid_ff || rsp_ready;
      stall     = cand_ok && pend_valid_ff && !out_free;
      step_end  = sub_ff == last_sub;

      push      = (cmd.emit && cand_ok && pend_valid_ff && out_free) ||
                  (cmd.flush && pend_valid_ff && out_free);
      push_last = cmd.flush;

      sts.glyph      = !is_bar && !is_digit;
      sts.emit_last  = !stall && step_end && cidx_ff == 3'd4;
      sts.flush_done = !pend_valid_ff || out_free;
   end

   always_comb begin
      ptr_in        = ptr_ff;
      col_in        = col_ff;
      line_in       = line_ff;
      size_in       = size_ff;
      code_in       = code_ff;
      glyph_in      = glyph_ff;
      run_in        = run_ff;
      cidx_in       = cidx_ff;
      sub_in        = sub_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (cmd.capture) begin
         code_in = req_data.char_code;
         if (req_data.new_text) begin
            ptr_in  = '0;
            col_in  = '0;
            line_in = '0;
            size_in = SIZE_ONE;
         end
      end

      if (cmd.decode) begin
         if (is_bar) begin
            line_in = line_inc;
            ptr_in  = bar_over ? PTR_W'(FRAME_BYTES) : PTR_W'(bar_addr);
            col_in  = bar_over ? COL_AT_END : '0;
         end else begin
            ptr_in = adv_over ? PTR_W'(FRAME_BYTES) : PTR_W'(adv_sum);
            col_in = adv_over ? COL_AT_END : COL_W'(col_sum);
            if (is_digit) begin
               priority if (code_ff == CODE_SIZE1) size_in = SIZE_ONE;
               else if (code_ff == CODE_SIZE2)     size_in = SIZE_TWO;
               else                                size_in = SIZE_FOUR;
            end else begin
               glyph_in = in_table ? glyph_bits(rom_idx) : '0;
               run_in   = ADDR_W'(ptr_ff);
               cidx_in  = '0;
               sub_in   = '0;
            end
         end
      end

      // one candidate back is held so the final write can carry the last flag
      if (cmd.emit && !stall) begin
         if (step_end) begin
            sub_in  = '0;
            cidx_in = cidx_ff + 3'd1;
            run_in  = run_ff + ((size_ff == SIZE_ONE) ? ADDR_W'(1) : ADDR_W'(2));
         end else begin
            sub_in = sub_ff + 2'd1;
         end
         if (cand_ok) begin
            pend_valid_in = 1'b1;
            pend_addr_in  = cand_addr;
            pend_data_in  = cand_data;
         end
      end

      if (cmd.flush && out_free) pend_valid_in = 1'b0;

      if (push) begin
         rsp_valid_in      = 1'b1;
         rsp_in.fb_address = pend_addr_ff[FB_ADDR_W-1:0];
         rsp_in.fb_data    = pend_data_ff;
         rsp_in.last_write = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         col_ff        <= '0;
         line_ff       <= '0;
         size_ff       <= SIZE_ONE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ptr_ff        <= ptr_in;
         col_ff        <= col_in;
         line_ff       <= line_in;
         size_ff       <= size_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      glyph_ff     <= glyph_in;
      run_ff       <= run_in;
      cidx_ff      <= cidx_in;
      sub_ff       <= sub_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_ptr_in_frame: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(FRAME_BYTES))
      else $error("write pointer beyond frame");

   a_col_tracks: assert property (@(posedge clock) disable iff (reset)
      (ptr_ff < PTR_W'(FRAME_BYTES)) |-> (col_ff < COL_W'(ROW_BYTES - 1) ||
                                          col_ff == COL_W'(ROW_BYTES - 1)))
      else $error("column counter out of row");

   a_pend_addr: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> pend_addr_ff < F_A)
      else $error("held write outside frame");

   a_size_code: assert property (@(posedge clock) disable iff (reset)
      size_ff == SIZE_ONE || size_ff == SIZE_TWO || size_ff == SIZE_FOUR)
      else $error("bad size mode");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (push && push_last) |=> !pend_valid_ff)
      else $error("held write left after last write");

endmodule

// ===== rtl/text_to_framebuffer_renderer.sv =====
// Character to framebuffer byte writes, 5x7 column font, one write per cycle
// while not stalled. A '|' or a size digit gives no write. A glyph gives up
// to N = 5, 10 or 20 writes for size 1, 2 or 4; each write is held one
// candidate back and then registered at the output;
// rsp_ready low stalls the column sequencer. One character at a time.
// Reset clears pointer, line and size and empties the output; no clearing pass.
module text_to_framebuffer_renderer #(
   parameter int ROW_BYTES   = t2fb_pkg::ROW_BYTES_DEF,
   parameter int FRAME_BYTES = t2fb_pkg::FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  t2fb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output t2fb_pkg::rsp_type rsp_data
);
   import t2fb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   t2fb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   t2fb_dp #(
      .ROW_BYTES   (ROW_BYTES),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
